// ===== hw/rtl/pol_pkg.sv =====
`default_nettype none

package pol_pkg;

    // Request codes carried in the opcode field.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_NULL  = 2'd3
    } t_status;

    localparam int POS_W    = 8;
    localparam int HANDLE_W = 16;
    localparam int COUNT_W  = 9;

    typedef struct packed {
        t_opcode               opcode;
        logic [POS_W-1:0]      position;
        logic [HANDLE_W-1:0]   song_handle;
    } t_in_beat;

    typedef struct packed {
        t_status               status;
        logic [HANDLE_W-1:0]   read_handle;
        logic [COUNT_W-1:0]    entry_count;
        logic                  list_empty;
    } t_out_beat;

    // Commands broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic ins_en;    // open a gap at the position and load the handle
        logic rem_en;    // close the gap at the position
        logic rd_load;   // copy every entry into its read register
        logic rd_shift;  // move the read registers one cell toward cell zero
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/positional_ordered_list_top.sv =====
// Ordered list of nonzero 16-bit handles held in a row of CAPACITY cells, one
// entry per cell. Insert and remove edit the whole row together: every cell
// compares its own index with the broadcast position and either loads the new
// handle, takes its neighbor's entry, or holds; clear only resets the count.
// Insert, remove, clear, and a read at or past the count load their result
// into the output register at acceptance. A read that hits copies the row into
// a second chain of read registers and shifts it toward cell zero once per
// cycle; the result is taken from cell zero of that chain once the entry at the
// position has reached it. One request is in flight at a time, and a new
// beat is stalled while a read shifts or while an earlier result is still
// held by a stall on the output side. Entries above the count are never read
// and need no reset; only the count and the handshake control are cleared.
`default_nettype none

module positional_ordered_list_top #(
    parameter int CAPACITY = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire pol_pkg::t_in_beat  i_in_beat,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output pol_pkg::t_out_beat      o_out_beat
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Common width for comparing the 8-bit position against the count.
    localparam int CMP_W = (CNT_W > pol_pkg::POS_W) ? CNT_W : pol_pkg::POS_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state                         r_state, n_state;
    logic [CNT_W-1:0]               r_count, n_count;
    logic [pol_pkg::POS_W-1:0]      r_rd_left, n_rd_left;
    logic                           r_out_valid;
    pol_pkg::t_out_beat             r_out;

    logic                           w_in_acc;
    logic                           w_full;
    logic                           w_ins_ok;
    logic                           w_rem_ok;
    logic                           w_rd_hit;
    logic                           w_rd_done;
    logic                           w_load_out;
    logic [CMP_W-1:0]               w_pos_ext;
    logic [CMP_W-1:0]               w_cnt_ext;
    logic [CMP_W-1:0]               w_last_ext;
    logic [CMP_W-1:0]               w_sel_pos;
    logic [IDX_W-1:0]               w_cell_pos;
    pol_pkg::t_cell_ctl             w_ctl;
    pol_pkg::t_out_beat             w_res;

    logic [pol_pkg::HANDLE_W-1:0]   w_entry [CAPACITY];
    logic [pol_pkg::HANDLE_W-1:0]   w_rd    [CAPACITY];

    // A new beat waits while a read is shifting or the output register is
    // holding a result that the far side has not taken.
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_pos_ext  = CMP_W'(i_in_beat.position);
    assign w_cnt_ext  = CMP_W'(r_count);
    assign w_last_ext = w_cnt_ext - CMP_W'(1);
    assign w_full     = (r_count == CNT_W'(CAPACITY));

    // A null handle is refused before fullness is considered.
    assign w_ins_ok = w_in_acc && (i_in_beat.opcode == pol_pkg::OP_INSERT)
                      && (i_in_beat.song_handle != '0) && !w_full;
    assign w_rem_ok = w_in_acc && (i_in_beat.opcode == pol_pkg::OP_REMOVE)
                      && (r_count != '0);
    assign w_rd_hit = w_in_acc && (i_in_beat.opcode == pol_pkg::OP_READ)
                      && (w_pos_ext < w_cnt_ext);

    // Insert clamps to the count (append); remove clamps to the last entry.
    always_comb begin
        if (i_in_beat.opcode == pol_pkg::OP_INSERT) begin
            w_sel_pos = (w_pos_ext > w_cnt_ext) ? w_cnt_ext : w_pos_ext;
        end else begin
            w_sel_pos = (w_pos_ext > w_last_ext) ? w_last_ext : w_pos_ext;
        end
    end
    assign w_cell_pos = IDX_W'(w_sel_pos);

    assign w_rd_done = (r_state == S_READ) && (r_rd_left == '0);

    always_comb begin
        w_ctl.ins_en   = w_ins_ok;
        w_ctl.rem_en   = w_rem_ok;
        w_ctl.rd_load  = w_rd_hit;
        w_ctl.rd_shift = (r_state == S_READ) && !w_rd_done;
    end

    // The row of cells. Cell zero has no left neighbor and the last cell no
    // right neighbor; the missing inputs read as zero and are never used
    // for an entry below the count.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [pol_pkg::HANDLE_W-1:0] w_left;
        logic [pol_pkg::HANDLE_W-1:0] w_right;
        logic [pol_pkg::HANDLE_W-1:0] w_rd_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right    = '0;
            assign w_rd_right = '0;
        end else begin : g_mid_r
            assign w_right    = w_entry[g+1];
            assign w_rd_right = w_rd[g+1];
        end

        pol_cell #(
            .IDX_W (IDX_W),
            .INDEX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_pos      (w_cell_pos),
            .i_handle   (i_in_beat.song_handle),
            .i_left     (w_left),
            .i_right    (w_right),
            .i_rd_right (w_rd_right),
            .o_entry    (w_entry[g]),
            .o_rd       (w_rd[g])
        );
    end

    // Next count and the result of a request that finishes at acceptance.
    always_comb begin
        n_count = r_count;
        w_res.status = pol_pkg::ST_DONE;
        w_res.read_handle = '0;
        if (w_in_acc) begin
            unique case (i_in_beat.opcode)
                pol_pkg::OP_INSERT: begin
                    priority if (i_in_beat.song_handle == '0) begin
                        w_res.status = pol_pkg::ST_NULL;
                    end else if (w_full) begin
                        w_res.status = pol_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                pol_pkg::OP_REMOVE: begin
                    if (r_count == '0) begin
                        w_res.status = pol_pkg::ST_RANGE;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                pol_pkg::OP_READ: begin
                    if (!w_rd_hit) begin
                        w_res.status = pol_pkg::ST_RANGE;
                    end
                end
                pol_pkg::OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
        if (w_rd_done) begin
            w_res.read_handle = w_rd[0];
        end
        w_res.entry_count = pol_pkg::COUNT_W'(n_count);
        w_res.list_empty  = (n_count == '0);
    end

    assign w_load_out = (w_in_acc && !w_rd_hit) || w_rd_done;

    always_comb begin
        n_state   = r_state;
        n_rd_left = r_rd_left;
        unique case (r_state)
            S_IDLE: begin
                if (w_rd_hit) begin
                    n_state   = S_READ;
                    n_rd_left = i_in_beat.position;
                end
            end
            S_READ: begin
                if (w_rd_done) begin
                    n_state = S_IDLE;
                end else begin
                    n_rd_left = r_rd_left - pol_pkg::POS_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_left <= n_rd_left;
        if (w_load_out) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // The count never passes the capacity of the row.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // While a read shifts, no result is pending in the output register.
    a_read_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("result pending during a read");

    // An accepted clear presents an empty list on the next cycle.
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_beat.opcode == pol_pkg::OP_CLEAR))
        |=> (o_out_valid && o_out_beat.list_empty && (r_count == '0)))
        else $error("clear did not empty the list");

    // A successful insert grows the count by exactly one.
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_ok |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the count");

endmodule

`default_nettype wire

// ===== hw/rtl/pol_cell.sv =====
`default_nettype none

module pol_cell #(
    parameter int IDX_W = 8,
    parameter int INDEX = 0
) (
    input  wire logic                          i_clk,
    input  wire pol_pkg::t_cell_ctl            i_ctl,
    input  wire logic [IDX_W-1:0]              i_pos,
    input  wire logic [pol_pkg::HANDLE_W-1:0]  i_handle,
    input  wire logic [pol_pkg::HANDLE_W-1:0]  i_left,
    input  wire logic [pol_pkg::HANDLE_W-1:0]  i_right,
    input  wire logic [pol_pkg::HANDLE_W-1:0]  i_rd_right,
    output logic      [pol_pkg::HANDLE_W-1:0]  o_entry,
    output logic      [pol_pkg::HANDLE_W-1:0]  o_rd
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [pol_pkg::HANDLE_W-1:0] r_entry;
    logic [pol_pkg::HANDLE_W-1:0] r_rd;

    // An insert moves every entry at or above the position up by one; a
    // remove pulls every entry above the position down by one.
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.ins_en && (MY_IDX == i_pos)) begin
            r_entry <= i_handle;
        end else if (i_ctl.ins_en && (MY_IDX > i_pos)) begin
            r_entry <= i_left;
        end else if (i_ctl.rem_en && (MY_IDX >= i_pos)) begin
            r_entry <= i_right;
        end else begin
            r_entry <= r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.rd_load) begin
            r_rd <= r_entry;
        end else if (i_ctl.rd_shift) begin
            r_rd <= i_rd_right;
        end else begin
            r_rd <= r_rd;
        end
    end

    assign o_entry = r_entry;
    assign o_rd    = r_rd;

endmodule

`default_nettype wire
